### rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // Default sizing of the queue
  localparam int SPQ_DEPTH     = 16;
  localparam int SPQ_PRIO_BITS = 8;

  // Fixed field widths of the item payloads
  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 8;
  localparam int OCC_W   = 5;

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic                      kind;
    logic signed [VALUE_W-1:0] data_value;
    logic [PRIO_W-1:0]         priority_in;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] out_value;
    logic [PRIO_W-1:0]         out_priority;
    logic [OCC_W-1:0]          occupancy;
    logic                      is_empty;
    logic                      is_full;
  } out_item_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/spq_cell.sv
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int PW = SPQ_PRIO_BITS
) (
  input  wire logic                      clk,
  input  wire cell_ctl_t                 ctl,
  input  wire logic                      occ,
  input  wire logic signed [VALUE_W-1:0] new_value,
  input  wire logic [PW-1:0]             new_prio,
  input  wire logic signed [VALUE_W-1:0] prev_value,
  input  wire logic [PW-1:0]             prev_prio,
  input  wire logic                      prev_stay,
  input  wire logic signed [VALUE_W-1:0] next_value,
  input  wire logic [PW-1:0]             next_prio,
  output logic signed [VALUE_W-1:0]      value,
  output logic [PW-1:0]                  prio,
  output logic                           stay
);

  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic [PW-1:0]             prio_r, prio_nxt;

  // Keep the entry when it ranks at or ahead of the incoming one
  assign stay = occ && (prio_r <= new_prio);

  // Pick the next entry: hold, take the new item, or shift from a neighbour
  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (ctl.ins && !stay) begin
      if (prev_stay) begin
        value_nxt = new_value;
        prio_nxt  = new_prio;
      end else begin
        value_nxt = prev_value;
        prio_nxt  = prev_prio;
      end
    end else if (ctl.rem) begin
      value_nxt = next_value;
      prio_nxt  = next_prio;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign value = value_r;
  assign prio  = prio_r;

endmodule

`default_nettype wire

### rtl/sorted_priority_queue_top.sv
// Sorted priority queue of up to DEPTH entries, each a 32-bit value with a
// priority number; the smallest number is served first, ties leave in
// arrival order.
// Input channel (in_valid, in_stall, in_item): kind 0 inserts data_value
// with priority_in, kind 1 removes the head entry. Output channel
// (out_valid, out_stall, out_item): one result per item with status, the
// removed entry (zero otherwise), occupancy and empty/full flags.
// Storage is a row of DEPTH cells; every cell compares its priority with
// the incoming one and keeps, takes or shifts its entry.
// Each result is registered in the output register, or in the skid
// register while the output is stalled. One item per cycle while in_stall is low.
// A stalled result holds in the output register; one further item is
// caught in a skid register, after which in_stall rises until the output
// drains.
// Reset clears the entry count and both result valid flags; cell contents
// are not cleared and are never read before being written.
`default_nettype none

module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int DEPTH         = SPQ_DEPTH,
  parameter int PRIORITY_BITS = SPQ_PRIO_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = PRIORITY_BITS;

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, skid_valid_r;
  out_item_t     out_r, skid_r, res;

  logic          accept, out_fire, full, empty;
  cell_ctl_t     ctl;
  logic [PW-1:0] new_prio;
  logic [PW+PRIO_W-1:0] prio_in_ext, head_prio_ext;
  logic [CW+OCC_W-1:0]  occ_ext;

  logic signed [VALUE_W-1:0] cell_value [DEPTH];
  logic [PW-1:0]             cell_prio  [DEPTH];
  logic [DEPTH-1:0]          cell_stay;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  // Use only the low PRIORITY_BITS of the incoming priority
  assign prio_in_ext = (PW + PRIO_W)'(in_item.priority_in);
  assign new_prio    = prio_in_ext[PW-1:0];

  assign ctl.ins = accept && (in_item.kind == KIND_INSERT) && !full;
  assign ctl.rem = accept && (in_item.kind == KIND_REMOVE) && !empty;

  // Row of cells, head at index 0; nothing ranks ahead of the head cell
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int PREV = (i == 0) ? 0 : i - 1;
    localparam int NEXT = (i == DEPTH - 1) ? i : i + 1;
    logic occ;
    logic prev_stay;

    assign occ       = (CW'(i) < count_r);
    assign prev_stay = (i == 0) ? 1'b1 : cell_stay[PREV];

    spq_cell #(
      .PW(PW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ),
      .new_value  (in_item.data_value),
      .new_prio   (new_prio),
      .prev_value (cell_value[PREV]),
      .prev_prio  (cell_prio[PREV]),
      .prev_stay  (prev_stay),
      .next_value (cell_value[NEXT]),
      .next_prio  (cell_prio[NEXT]),
      .value      (cell_value[i]),
      .prio       (cell_prio[i]),
      .stay       (cell_stay[i])
    );
  end

  // Advance the entry count
  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Build the result of the item being accepted
  assign head_prio_ext = (PW + PRIO_W)'(cell_prio[0]);
  assign occ_ext       = (CW + OCC_W)'(count_nxt);

  always_comb begin
    res              = '0;
    res.status       = ST_OK;
    res.occupancy    = occ_ext[OCC_W-1:0];
    res.is_empty     = (count_nxt == '0);
    res.is_full      = (count_nxt == CW'(DEPTH));
    if (in_item.kind == KIND_INSERT) begin
      if (full) begin
        res.status = ST_OVERFLOW;
      end
    end else begin
      if (empty) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.out_value    = cell_value[0];
        res.out_priority = head_prio_ext[PRIO_W-1:0];
      end
    end
  end

  // Count and result registers with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (!out_valid_r || out_fire) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= accept;
        end
      end else if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Result payloads
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

### rtl/spq_port_chk.sv
`default_nettype none

module spq_port_chk
  import spq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // Hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Drop all results at reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // Underflow only from an empty queue, with a zero entry
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_UNDERFLOW) |->
      out_item.is_empty && (out_item.out_value == '0) && (out_item.out_priority == '0))
    else $error("bad underflow result");

  // Overflow leaves the queue full
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_OVERFLOW) |->
      out_item.is_full && !out_item.is_empty)
    else $error("bad overflow result");

endmodule

bind sorted_priority_queue_top spq_port_chk u_spq_port_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
